### rtl/dsfb_pkg.sv
`timescale 1ns / 1ps

package dsfb_pkg;

   // Framing characters.
   localparam logic [7:0] SYN_CHAR = 8'h16;
   localparam logic [7:0] DLE_CHAR = 8'h10;
   localparam logic [7:0] STX_CHAR = 8'h02;
   localparam logic [7:0] ETX_CHAR = 8'h03;

   // Configuration register indexes.
   localparam logic CSR_CRC_POLYNOMIAL = 1'b0;
   localparam logic CSR_CRC_START      = 1'b1;

   localparam logic [15:0] CRC_POLYNOMIAL_RESET = 16'hA001;
   localparam logic [15:0] CRC_START_RESET      = 16'h0000;

   // Emitter step codes, one per line byte that an item can produce.
   localparam logic [3:0] STEP_SYN      = 4'd0;
   localparam logic [3:0] STEP_DLE_HEAD = 4'd1;
   localparam logic [3:0] STEP_STX      = 4'd2;
   localparam logic [3:0] STEP_DATA     = 4'd3;
   localparam logic [3:0] STEP_DUP      = 4'd4;
   localparam logic [3:0] STEP_DLE_TAIL = 4'd5;
   localparam logic [3:0] STEP_ETX      = 4'd6;
   localparam logic [3:0] STEP_CRC_LOW  = 4'd7;
   localparam logic [3:0] STEP_CRC_HIGH = 4'd8;

   // One payload byte with everything the emitter needs to frame it.
   typedef struct packed {
      logic        header;
      logic [7:0]  data;
      logic        is_dle;
      logic        last;
      logic [15:0] crc;
   } record_type;

   // Reflected CRC-16 update of one byte, eight shift steps.
   function automatic logic [15:0] crc_feed(input logic [15:0] crc_value,
                                            input logic [7:0]  data,
                                            input logic [15:0] polynomial);
      logic [15:0] acc;
      acc = crc_value ^ {8'h00, data};
      for (int k = 0; k < 8; k++) begin
         if (acc[0]) begin
            acc = (acc >> 1) ^ polynomial;
         end else begin
            acc = acc >> 1;
         end
      end
      return acc;
   endfunction

endpackage

### rtl/dsfb_crc_stage.sv
`timescale 1ns / 1ps

module dsfb_crc_stage
   import dsfb_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_payload_byte,
   input  logic        req_payload_last,
   input  logic [15:0] crc_polynomial,
   input  logic [15:0] crc_start,
   output logic        rec_valid,
   input  logic        rec_ready,
   output record_type  rec
);

   logic        q_valid_ff;
   logic        q_valid_in;
   logic [7:0]  q_byte_ff;
   logic        q_last_ff;
   logic        header_sent_ff;
   logic        header_sent_in;
   logic [15:0] running_crc_ff;
   logic [15:0] running_crc_in;
   logic [15:0] crc_base;
   logic [15:0] crc_next;
   logic        q_take;

   // Input register: refills in the same cycle that its item moves on.
   assign q_take    = q_valid_ff && rec_ready;
   assign req_ready = !q_valid_ff || rec_ready;
   assign rec_valid = q_valid_ff;

   always_comb begin
      q_valid_in = q_valid_ff;
      if (req_valid && req_ready) begin
         q_valid_in = 1'b1;
      end else if (q_take) begin
         q_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         q_valid_ff <= 1'b0;
      end else begin
         q_valid_ff <= q_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         q_byte_ff <= req_payload_byte;
         q_last_ff <= req_payload_last;
      end
   end

   // A frame opens with the start value; the CRC covers the unstuffed byte.
   assign crc_base = header_sent_ff ? running_crc_ff : crc_start;
   assign crc_next = crc_feed(crc_base, q_byte_ff, crc_polynomial);

   always_comb begin
      rec.header = !header_sent_ff;
      rec.data   = q_byte_ff;
      rec.is_dle = (q_byte_ff == DLE_CHAR);
      rec.last   = q_last_ff;
      rec.crc    = crc_next;
   end

   // Frame state advances on each transfer to the emitter and clears on close.
   always_comb begin
      header_sent_in = header_sent_ff;
      running_crc_in = running_crc_ff;
      if (q_take) begin
         if (q_last_ff) begin
            header_sent_in = 1'b0;
            running_crc_in = 16'h0000;
         end else begin
            header_sent_in = 1'b1;
            running_crc_in = crc_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         header_sent_ff <= 1'b0;
         running_crc_ff <= 16'h0000;
      end else begin
         header_sent_ff <= header_sent_in;
         running_crc_ff <= running_crc_in;
      end
   end

   // A closed frame leaves no CRC behind.
   assert property (@(posedge clock) disable iff (reset)
      q_take && q_last_ff |=> !header_sent_ff && (running_crc_ff == 16'h0000))
      else $error("frame state not cleared after last byte");

   // Without an open frame there is no running CRC.
   assert property (@(posedge clock) disable iff (reset)
      !header_sent_ff |-> (running_crc_ff == 16'h0000))
      else $error("running CRC held with no frame open");

   // An item waiting for the emitter stays in the input register unchanged.
   assert property (@(posedge clock) disable iff (reset)
      q_valid_ff && !rec_ready |=> q_valid_ff && $stable(q_byte_ff) && $stable(q_last_ff))
      else $error("input register changed while its item was waiting");

endmodule

### rtl/dsfb_emitter.sv
`timescale 1ns / 1ps

module dsfb_emitter
   import dsfb_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        rec_valid,
   output logic        rec_ready,
   input  record_type  rec,
   input  logic [15:0] crc_polynomial,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_line_byte,
   output logic        rsp_run_last,
   output logic        rsp_frame_end
);

   logic        busy_ff;
   logic        busy_in;
   record_type  rec_ff;
   logic [3:0]  step_ff;
   logic [3:0]  step_in;
   logic [3:0]  step_next;
   logic        step_final;
   logic [7:0]  step_byte;
   logic [15:0] crc_final;
   logic        out_load;
   logic        rsp_valid_ff;
   logic [7:0]  rsp_line_byte_ff;
   logic        rsp_run_last_ff;
   logic        rsp_frame_end_ff;

   // The closing CRC adds ETX to the CRC that the payload byte left.
   assign crc_final = crc_feed(rec_ff.crc, ETX_CHAR, crc_polynomial);

   // Byte, successor and end flag of the current step.
   always_comb begin
      step_byte  = DLE_CHAR;
      step_next  = STEP_DATA;
      step_final = 1'b0;
      unique case (step_ff)
         STEP_SYN: begin
            step_byte = SYN_CHAR;
            step_next = STEP_DLE_HEAD;
         end
         STEP_DLE_HEAD: begin
            step_byte = DLE_CHAR;
            step_next = STEP_STX;
         end
         STEP_STX: begin
            step_byte = STX_CHAR;
            step_next = STEP_DATA;
         end
         STEP_DATA: begin
            step_byte = rec_ff.data;
            if (rec_ff.is_dle) begin
               step_next = STEP_DUP;
            end else begin
               step_next  = STEP_DLE_TAIL;
               step_final = !rec_ff.last;
            end
         end
         STEP_DUP: begin
            step_byte  = DLE_CHAR;
            step_next  = STEP_DLE_TAIL;
            step_final = !rec_ff.last;
         end
         STEP_DLE_TAIL: begin
            step_byte = DLE_CHAR;
            step_next = STEP_ETX;
         end
         STEP_ETX: begin
            step_byte = ETX_CHAR;
            step_next = STEP_CRC_LOW;
         end
         STEP_CRC_LOW: begin
            step_byte = crc_final[7:0];
            step_next = STEP_CRC_HIGH;
         end
         STEP_CRC_HIGH: begin
            step_byte  = crc_final[15:8];
            step_next  = STEP_SYN;
            step_final = 1'b1;
         end
         default: begin
            step_byte  = DLE_CHAR;
            step_next  = STEP_SYN;
            step_final = 1'b1;
         end
      endcase
   end

   // The output register takes a byte whenever it is empty or being drained.
   assign out_load  = !rsp_valid_ff || rsp_ready;
   assign rec_ready = !busy_ff || (out_load && step_final);

   always_comb begin
      busy_in = busy_ff;
      step_in = step_ff;
      if (rec_valid && rec_ready) begin
         busy_in = 1'b1;
         step_in = rec.header ? STEP_SYN : STEP_DATA;
      end else if (busy_ff && out_load) begin
         if (step_final) begin
            busy_in = 1'b0;
         end else begin
            step_in = step_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         step_ff      <= STEP_SYN;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
         if (out_load) begin
            rsp_valid_ff <= busy_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rec_valid && rec_ready) begin
         rec_ff <= rec;
      end
      if (out_load) begin
         rsp_line_byte_ff <= step_byte;
         rsp_run_last_ff  <= step_final;
         rsp_frame_end_ff <= (step_ff == STEP_CRC_HIGH);
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_line_byte = rsp_line_byte_ff;
   assign rsp_run_last  = rsp_run_last_ff;
   assign rsp_frame_end = rsp_frame_end_ff;

   // Header steps belong only to the first byte of a frame.
   assert property (@(posedge clock) disable iff (reset)
      busy_ff && (step_ff == STEP_SYN || step_ff == STEP_DLE_HEAD || step_ff == STEP_STX)
      |-> rec_ff.header)
      else $error("header emitted inside an open frame");

   // The doubled DLE comes only from a DLE payload byte.
   assert property (@(posedge clock) disable iff (reset)
      busy_ff && (step_ff == STEP_DUP) |-> rec_ff.is_dle)
      else $error("stuffing byte for a non-DLE payload byte");

   // The frame closes on the last byte of its item.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_frame_end_ff |-> rsp_run_last_ff)
      else $error("frame end not on the last byte of an item");

endmodule

### rtl/dle_stuffed_frame_builder.sv
`timescale 1ns / 1ps
// The first line byte of an item passes through the input register, the emitter's step
// state and the output register. One line byte per cycle while rsp_ready stays high;
// an item produces 1 to 9 line bytes (header 3, payload 1 or 2, trailer 4).
// Reset (synchronous, active high) closes any open frame, empties all stages and
// loads the polynomial 0xA001 and start value 0x0000.

module dle_stuffed_frame_builder
   import dsfb_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_payload_byte,
   input  logic        req_payload_last,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_line_byte,
   output logic        rsp_run_last,
   output logic        rsp_frame_end,
   input  logic        csr_write_enable,
   input  logic        csr_index,
   input  logic [15:0] csr_write_data
);

   logic [15:0] crc_polynomial_ff;
   logic [15:0] crc_start_ff;
   logic        rec_valid;
   logic        rec_ready;
   record_type  rec;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         crc_polynomial_ff <= CRC_POLYNOMIAL_RESET;
         crc_start_ff      <= CRC_START_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_CRC_POLYNOMIAL: crc_polynomial_ff <= csr_write_data;
            CSR_CRC_START:      crc_start_ff      <= csr_write_data;
            default:            crc_start_ff      <= crc_start_ff;
         endcase
      end
   end

   // Input register, frame state and payload CRC.
   dsfb_crc_stage u_crc_stage (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_payload_byte (req_payload_byte),
      .req_payload_last (req_payload_last),
      .crc_polynomial   (crc_polynomial_ff),
      .crc_start        (crc_start_ff),
      .rec_valid        (rec_valid),
      .rec_ready        (rec_ready),
      .rec              (rec)
   );

   // Byte sequencer and output register.
   dsfb_emitter u_emitter (
      .clock          (clock),
      .reset          (reset),
      .rec_valid      (rec_valid),
      .rec_ready      (rec_ready),
      .rec            (rec),
      .crc_polynomial (crc_polynomial_ff),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_line_byte  (rsp_line_byte),
      .rsp_run_last   (rsp_run_last),
      .rsp_frame_end  (rsp_frame_end)
   );

endmodule

### verif/tb_dle_stuffed_frame_builder.sv
`timescale 1ns / 1ps

module tb_dle_stuffed_frame_builder
   import dsfb_pkg::*;
();

   localparam int CYCLE_LIMIT    = 400000;
   localparam int RANDOM_ITEMS   = 400;
   localparam int REPORT_LIMIT   = 10;
   localparam int SETTLE_CYCLES  = 4;

   // One line byte as it should leave the block.
   typedef struct packed {
      logic [7:0] line_byte;
      logic       run_last;
      logic       frame_end;
   } line_beat_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [7:0]  req_payload_byte;
   logic        req_payload_last;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [7:0]  rsp_line_byte;
   logic        rsp_run_last;
   logic        rsp_frame_end;
   logic        csr_write_enable;
   logic        csr_index;
   logic [15:0] csr_write_data;

   // Predicted line stream, oldest first.
   line_beat_type line_bytes_due[$];

   // Shadow of the block's registers and frame state.
   logic [15:0] poly_shadow;
   logic [15:0] start_shadow;
   logic [15:0] frame_crc;
   logic        frame_open;

   int          error_count;
   int          cycle_count;
   int          payload_count;
   int          frames_closed;
   int          beats_checked;
   int          csr_writes;
   int          ready_hold;
   bit          no_idling;

   dle_stuffed_frame_builder i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_payload_byte (req_payload_byte),
      .req_payload_last (req_payload_last),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_line_byte    (rsp_line_byte),
      .rsp_run_last     (rsp_run_last),
      .rsp_frame_end    (rsp_frame_end),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   // Free-running clock.
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Watchdog on the total run length.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d line bytes still due.",
                  cycle_count, line_bytes_due.size());
         $display("tb_dle_stuffed_frame_builder failed");
         $finish;
      end
   end

   // Idle cycles before the next transfer; mostly short, sometimes long.
   function automatic int draw_idle_cycles();
      if (no_idling) begin
         return 0;
      end
      case ($urandom_range(0, 3)) inside
         0, 1: return 0;
         2: return $urandom_range(1, 3);
         default: return $urandom_range(0, 13);
      endcase
   endfunction

   // One reflected CRC-16 byte update, low bit first.
   function automatic logic [15:0] crc16_reflect_byte(input logic [15:0] crc_in,
                                                      input logic [7:0]  data_in);
      logic [15:0] shift_reg;
      shift_reg = {crc_in[15:8], crc_in[7:0] ^ data_in};
      repeat (8) begin
         shift_reg = shift_reg[0] ? ({1'b0, shift_reg[15:1]} ^ poly_shadow)
                                  : {1'b0, shift_reg[15:1]};
      end
      return shift_reg;
   endfunction

   // Works out the line bytes one payload byte produces and queues them.
   task automatic frame_and_stuff(input logic [7:0] data_in, input logic last_in);
      line_beat_type run_beats[$];
      logic [15:0]   closing_crc;
      if (!frame_open) begin
         run_beats.push_back('{SYN_CHAR, 1'b0, 1'b0});
         run_beats.push_back('{DLE_CHAR, 1'b0, 1'b0});
         run_beats.push_back('{STX_CHAR, 1'b0, 1'b0});
         frame_crc  = start_shadow;
         frame_open = 1'b1;
      end
      run_beats.push_back('{data_in, 1'b0, 1'b0});
      frame_crc = crc16_reflect_byte(frame_crc, data_in);
      if (data_in == DLE_CHAR) begin
         run_beats.push_back('{DLE_CHAR, 1'b0, 1'b0});
      end
      if (last_in) begin
         closing_crc = crc16_reflect_byte(frame_crc, ETX_CHAR);
         run_beats.push_back('{DLE_CHAR, 1'b0, 1'b0});
         run_beats.push_back('{ETX_CHAR, 1'b0, 1'b0});
         run_beats.push_back('{closing_crc[7:0], 1'b0, 1'b0});
         run_beats.push_back('{closing_crc[15:8], 1'b0, 1'b1});
         frame_open = 1'b0;
         frame_crc  = 16'h0000;
         frames_closed++;
      end
      run_beats[run_beats.size() - 1].run_last = 1'b1;
      foreach (run_beats[k]) begin
         line_bytes_due.push_back(run_beats[k]);
      end
   endtask

   // Sends one payload byte. Valid stays high after the transfer so that a
   // back-to-back item never lowers and raises it in the same step.
   task automatic send_payload(input logic [7:0] data_in, input logic last_in);
      int gap;
      gap = draw_idle_cycles();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_payload_byte <= data_in;
      req_payload_last <= last_in;
      do @(posedge clock); while (!req_ready);
      frame_and_stuff(data_in, last_in);
      payload_count++;
   endtask

   // Sender holds off until every predicted line byte has come out.
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (line_bytes_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Register write; only called while the block is idle.
   task automatic write_crc_register(input logic index_in, input logic [15:0] value_in);
      csr_write_enable <= 1'b1;
      csr_index        <= index_in;
      csr_write_data   <= value_in;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      if (index_in == CSR_CRC_POLYNOMIAL) begin
         poly_shadow = value_in;
      end else begin
         start_shadow = value_in;
      end
      csr_writes++;
      @(posedge clock);
   endtask

   // Receiver: random stalls after each transfer, compare against the prediction.
   always @(posedge clock) begin
      line_beat_type want;
      if (reset) begin
         rsp_ready  <= 1'b0;
         ready_hold = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (line_bytes_due.size() == 0) begin
               error_count++;
               if (error_count <= REPORT_LIMIT) begin
                  $display("[%0t] Unexpected line byte %h (run_last %b, frame_end %b).",
                           $realtime, rsp_line_byte, rsp_run_last, rsp_frame_end);
               end
            end else begin
               want = line_bytes_due.pop_front();
               beats_checked++;
               if (rsp_line_byte !== want.line_byte || rsp_run_last !== want.run_last ||
                   rsp_frame_end !== want.frame_end) begin
                  error_count++;
                  if (error_count <= REPORT_LIMIT) begin
                     $display("[%0t] Mismatch: line_byte %h/%h run_last %b/%b frame_end %b/%b",
                              $realtime, want.line_byte, rsp_line_byte, want.run_last,
                              rsp_run_last, want.frame_end, rsp_frame_end);
                     $display("   (expected/actual)");
                  end
               end
            end
            ready_hold = draw_idle_cycles();
         end else if (ready_hold != 0) begin
            ready_hold--;
         end
         rsp_ready <= (ready_hold == 0);
      end
   end

   // Frames right after reset exercise the reset polynomial and start value.
   task automatic test_reset_values();
      send_payload(8'h31, 1'b0);
      send_payload(8'h32, 1'b0);
      send_payload(8'h33, 1'b1);
      send_payload(8'h00, 1'b1);
   endtask

   // Payload extremes, framing characters inside the payload and single-byte frames.
   task automatic test_payload_extremes();
      send_payload(8'h00, 1'b0);
      send_payload(8'hFF, 1'b0);
      send_payload(DLE_CHAR, 1'b0);
      send_payload(SYN_CHAR, 1'b0);
      send_payload(STX_CHAR, 1'b0);
      send_payload(ETX_CHAR, 1'b1);
      // A lone DLE frame produces the longest run of line bytes.
      send_payload(DLE_CHAR, 1'b1);
      send_payload(8'hFF, 1'b1);
   endtask

   // Register extremes for both the polynomial and the start value.
   task automatic test_register_extremes();
      wait_drained();
      write_crc_register(CSR_CRC_POLYNOMIAL, 16'h0000);
      write_crc_register(CSR_CRC_START, 16'hFFFF);
      send_payload(8'hA5, 1'b0);
      send_payload(8'h5A, 1'b1);
      wait_drained();
      write_crc_register(CSR_CRC_POLYNOMIAL, 16'hFFFF);
      write_crc_register(CSR_CRC_START, 16'h0000);
      send_payload(8'hFF, 1'b0);
      send_payload(8'h00, 1'b1);
   endtask

   // A new polynomial applies to the rest of an open frame.
   task automatic test_polynomial_mid_frame();
      wait_drained();
      write_crc_register(CSR_CRC_POLYNOMIAL, CRC_POLYNOMIAL_RESET);
      send_payload(8'h31, 1'b0);
      send_payload(DLE_CHAR, 1'b0);
      wait_drained();
      write_crc_register(CSR_CRC_POLYNOMIAL, 16'h8408);
      send_payload(8'h7E, 1'b1);
   endtask

   // A new start value only takes effect on the next frame.
   task automatic test_start_mid_frame();
      send_payload(8'h55, 1'b0);
      wait_drained();
      write_crc_register(CSR_CRC_START, 16'h1234);
      send_payload(8'hAA, 1'b1);
      send_payload(DLE_CHAR, 1'b1);
   endtask

   // Random payload byte, biased toward DLE and the other framing characters.
   function automatic logic [7:0] draw_payload_byte();
      case ($urandom_range(0, 7))
         0: return DLE_CHAR;
         1: begin
            case ($urandom_range(0, 2))
               0: return SYN_CHAR;
               1: return STX_CHAR;
               default: return ETX_CHAR;
            endcase
         end
         2: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // Random register value, with the extremes and the reset value mixed in.
   function automatic logic [15:0] draw_register_value(input logic [15:0] usual);
      case ($urandom_range(0, 5))
         0: return 16'h0000;
         1: return 16'hFFFF;
         2: return usual;
         default: return 16'($urandom_range(0, 65535));
      endcase
   endfunction

   // Well-formed frames of random length, with register changes between phases.
   task automatic test_random_frames();
      int sent;
      int phase;
      int frame_len;
      sent  = 0;
      phase = 0;
      while (sent < RANDOM_ITEMS) begin
         // Every phase starts with a drained block and fresh registers.
         wait_drained();
         write_crc_register(CSR_CRC_POLYNOMIAL, draw_register_value(CRC_POLYNOMIAL_RESET));
         write_crc_register(CSR_CRC_START, draw_register_value(CRC_START_RESET));
         no_idling = (phase % 3 == 1);
         repeat (8) begin
            // Stop at a frame boundary once enough bytes have gone out.
            if (sent >= RANDOM_ITEMS) begin
               break;
            end
            frame_len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40)
                                                    : $urandom_range(1, 8);
            for (int k = 1; k <= frame_len; k++) begin
               send_payload(draw_payload_byte(), k == frame_len);
               sent++;
            end
         end
         phase++;
      end
      no_idling = 1'b0;
      // Leave a frame open across the final drain and close it afterward.
      send_payload(draw_payload_byte(), 1'b0);
      wait_drained();
      send_payload(draw_payload_byte(), 1'b1);
   endtask

   // Main sequence.
   initial begin
      reset            <= 1'b1;
      req_valid        <= 1'b0;
      req_payload_byte <= 8'h00;
      req_payload_last <= 1'b0;
      csr_write_enable <= 1'b0;
      csr_index        <= CSR_CRC_POLYNOMIAL;
      csr_write_data   <= 16'h0000;
      poly_shadow   = CRC_POLYNOMIAL_RESET;
      start_shadow  = CRC_START_RESET;
      frame_crc     = 16'h0000;
      frame_open    = 1'b0;
      error_count   = 0;
      cycle_count   = 0;
      payload_count = 0;
      frames_closed = 0;
      beats_checked = 0;
      csr_writes    = 0;
      no_idling     = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_values();
      test_payload_extremes();
      test_register_extremes();
      test_polynomial_mid_frame();
      test_start_mid_frame();
      test_random_frames();

      wait_drained();
      repeat (20) @(posedge clock);
      if (line_bytes_due.size() != 0) begin
         error_count++;
         $display("%0d line bytes never arrived.", line_bytes_due.size());
      end

      $display("Sent %0d payload bytes in %0d closed frames and checked %0d line bytes.",
               payload_count, frames_closed, beats_checked);
      $display("Made %0d CRC register writes, including all-zero and all-one values.",
               csr_writes);
      if (error_count == 0) begin
         $display("tb_dle_stuffed_frame_builder passed");
      end else begin
         $display("%0d failures in total.", error_count);
         $display("tb_dle_stuffed_frame_builder failed");
      end
      $finish;
   end

endmodule

### files.f
rtl/dsfb_pkg.sv
rtl/dsfb_crc_stage.sv
rtl/dsfb_emitter.sv
rtl/dle_stuffed_frame_builder.sv
verif/tb_dle_stuffed_frame_builder.sv
